>>> src/cpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpp_pkg
// Shared widths, codes and types for the perspective projection block.
// ----------------------------------------------------------------------------
package cpp_pkg;

  localparam int CW  = 36;
  localparam int TW  = 30;
  localparam int PRW = CW + TW;
  localparam int QW  = 41;
  localparam int TOTW = QW + 2;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Z     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_YAW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_PITCH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_ROLL  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_OF_VIEW = 3'd6;

  localparam int ANG_W = 18;
  localparam logic signed [ANG_W-1:0] ANG_FULL = 18'sd46080;
  localparam logic signed [ANG_W-1:0] ANG_Q90  = 18'sd11520;
  localparam logic signed [ANG_W-1:0] ANG_Q180 = 18'sd23040;
  localparam logic signed [ANG_W-1:0] ANG_Q270 = 18'sd34560;

  localparam int CORDIC_STEPS = 24;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

  typedef logic signed [TW-1:0] trig_t;

  typedef struct packed {
    trig_t yaw_cos;
    trig_t yaw_sin;
    trig_t pitch_cos;
    trig_t pitch_sin;
    trig_t roll_cos;
    trig_t roll_sin;
    trig_t fov_cos;
    trig_t fov_sin;
  } cpp_trig_set_t;

  typedef enum logic [3:0] {
    TS_IDLE  = 4'b0001,
    TS_LOAD  = 4'b0010,
    TS_ITER  = 4'b0100,
    TS_STORE = 4'b1000
  } trig_state_t;

  function automatic logic signed [31:0] arc_entry(input logic [4:0] idx);
    logic signed [31:0] v;
    case (idx)
      5'd0:  v = 32'sd188743680;
      5'd1:  v = 32'sd111421900;
      5'd2:  v = 32'sd58872272;
      5'd3:  v = 32'sd29884485;
      5'd4:  v = 32'sd15000234;
      5'd5:  v = 32'sd7507429;
      5'd6:  v = 32'sd3754631;
      5'd7:  v = 32'sd1877430;
      5'd8:  v = 32'sd938729;
      5'd9:  v = 32'sd469366;
      5'd10: v = 32'sd234683;
      5'd11: v = 32'sd117342;
      5'd12: v = 32'sd58671;
      5'd13: v = 32'sd29335;
      5'd14: v = 32'sd14668;
      5'd15: v = 32'sd7334;
      5'd16: v = 32'sd3667;
      5'd17: v = 32'sd1833;
      5'd18: v = 32'sd917;
      5'd19: v = 32'sd458;
      5'd20: v = 32'sd229;
      5'd21: v = 32'sd115;
      5'd22: v = 32'sd57;
      5'd23: v = 32'sd29;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

>>> src/cpp_trig.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpp_trig
// Shared CORDIC unit: cosine and sine of yaw, pitch, roll and half field of
// view, rebuilt one angle after another after reset and after a register write.
// ----------------------------------------------------------------------------
module cpp_trig (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   restart,
  input  logic signed [15:0]     yaw,
  input  logic signed [15:0]     pitch,
  input  logic signed [15:0]     roll,
  input  logic [13:0]            fov,
  output logic                   busy,
  output cpp_pkg::cpp_trig_set_t trig
);
  import cpp_pkg::*;

  localparam logic [1:0] SEL_YAW   = 2'd0;
  localparam logic [1:0] SEL_PITCH = 2'd1;
  localparam logic [1:0] SEL_ROLL  = 2'd2;
  localparam logic [1:0] SEL_FOV   = 2'd3;

  trig_state_t state_r, state_nxt;
  logic [1:0] sel_r, sel_nxt;
  logic [4:0] step_r, step_nxt;
  logic signed [31:0] cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic [1:0] quad_r, quad_nxt;
  logic zero_r, zero_nxt;
  logic store_en;
  trig_t cos_r [4];
  trig_t sin_r [4];

  logic signed [ANG_W-1:0] h, h1, h2, h3, hr;
  logic [1:0] quad;
  logic [13:0] rr;
  logic signed [31:0] z_init, dx, dy, atan;
  logic signed [31:0] c0, s0, mc, ms, rc, rs;

  always_comb begin
    case (sel_r)
      SEL_YAW:   h = -($signed({{2{yaw[15]}}, yaw}) <<< 1);
      SEL_PITCH: h = -($signed({{2{pitch[15]}}, pitch}) <<< 1);
      SEL_ROLL:  h = -($signed({{2{roll[15]}}, roll}) <<< 1);
      SEL_FOV:   h = $signed({4'b0000, fov});
      default:   h = '0;
    endcase
    h1 = (h < 0) ? h + ANG_FULL : h;
    h2 = (h1 < 0) ? h1 + ANG_FULL : h1;
    h3 = (h2 >= ANG_FULL) ? h2 - ANG_FULL : h2;
    if (h3 >= ANG_Q270) begin
      quad = 2'd3;
      hr = h3 - ANG_Q270;
    end else if (h3 >= ANG_Q180) begin
      quad = 2'd2;
      hr = h3 - ANG_Q180;
    end else if (h3 >= ANG_Q90) begin
      quad = 2'd1;
      hr = h3 - ANG_Q90;
    end else begin
      quad = 2'd0;
      hr = h3;
    end
    rr = hr[13:0];
    z_init = $signed({3'b000, rr, 15'b0});
  end

  always_comb begin
    dx = cy_r >>> step_r;
    dy = cx_r >>> step_r;
    atan = arc_entry(step_r);
  end

  always_comb begin
    c0 = zero_r ? 32'sd1073741824 : cx_r;
    s0 = zero_r ? 32'sd0 : cy_r;
    case (quad_r)
      2'd0: begin mc = c0;  ms = s0;  end
      2'd1: begin mc = -s0; ms = c0;  end
      2'd2: begin mc = -c0; ms = -s0; end
      default: begin mc = s0; ms = -c0; end
    endcase
    rc = (mc + 32'sd2) >>> 2;
    rs = (ms + 32'sd2) >>> 2;
  end

  always_comb begin
    state_nxt = state_r;
    sel_nxt = sel_r;
    step_nxt = step_r;
    cx_nxt = cx_r;
    cy_nxt = cy_r;
    cz_nxt = cz_r;
    quad_nxt = quad_r;
    zero_nxt = zero_r;
    store_en = 1'b0;
    case (state_r)
      TS_IDLE: begin
      end
      TS_LOAD: begin
        cx_nxt = CORDIC_GAIN;
        cy_nxt = '0;
        cz_nxt = z_init;
        quad_nxt = quad;
        zero_nxt = (rr == '0);
        step_nxt = '0;
        state_nxt = TS_ITER;
      end
      TS_ITER: begin
        if (cz_r >= 0) begin
          cx_nxt = cx_r - dx;
          cy_nxt = cy_r + dy;
          cz_nxt = cz_r - atan;
        end else begin
          cx_nxt = cx_r + dx;
          cy_nxt = cy_r - dy;
          cz_nxt = cz_r + atan;
        end
        if (step_r == 5'(CORDIC_STEPS - 1)) begin
          state_nxt = TS_STORE;
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end
      TS_STORE: begin
        store_en = 1'b1;
        if (sel_r == SEL_FOV) begin
          state_nxt = TS_IDLE;
        end else begin
          sel_nxt = sel_r + 2'd1;
          state_nxt = TS_LOAD;
        end
      end
      default: state_nxt = TS_LOAD;
    endcase
    if (restart) begin
      state_nxt = TS_LOAD;
      sel_nxt = SEL_YAW;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TS_LOAD;
      sel_r <= SEL_YAW;
      step_r <= '0;
    end else begin
      state_r <= state_nxt;
      sel_r <= sel_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r <= cx_nxt;
    cy_r <= cy_nxt;
    cz_r <= cz_nxt;
    quad_r <= quad_nxt;
    zero_r <= zero_nxt;
    if (store_en) begin
      cos_r[sel_r] <= rc[TW-1:0];
      sin_r[sel_r] <= rs[TW-1:0];
    end
  end

  assign busy = (state_r != TS_IDLE);

  always_comb begin
    trig.yaw_cos   = cos_r[SEL_YAW];
    trig.yaw_sin   = sin_r[SEL_YAW];
    trig.pitch_cos = cos_r[SEL_PITCH];
    trig.pitch_sin = sin_r[SEL_PITCH];
    trig.roll_cos  = cos_r[SEL_ROLL];
    trig.roll_sin  = sin_r[SEL_ROLL];
    trig.fov_cos   = cos_r[SEL_FOV];
    trig.fov_sin   = sin_r[SEL_FOV];
  end

endmodule

>>> src/camera_perspective_projection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_perspective_projection
// Pinhole projection of world points to screen pixels, Q16.16 in and out.
// Throughput: one word per cycle while busy is low; 41 divider stages set the depth.
// The receiver cannot stall; every result shows for one cycle.
// Reset clears the valid bits and the camera position and angle registers and
// sets the field of view to 5760; the CORDIC unit then rebuilds its table and
// holds busy, and again after every register write.
// ----------------------------------------------------------------------------
module camera_perspective_projection #(
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [31:0]             in_point_x,
  input  logic signed [31:0]             in_point_y,
  input  logic signed [31:0]             in_point_z,
  output logic                           out_valid,
  output logic signed [31:0]             out_screen_x,
  output logic signed [31:0]             out_screen_y,
  output logic                           out_out_of_range,
  input  logic                           cfg_we,
  input  logic [cpp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data
);
  import cpp_pkg::*;

  localparam int SCW = $clog2(SCREEN_WIDTH + 1) + 15;
  localparam int PW  = PRW + SCW;
  localparam logic [SCW-1:0] SCALE = SCW'(longint'(SCREEN_WIDTH) * 32768);
  localparam logic signed [TOTW-1:0] CENTRE_X = TOTW'(longint'(SCREEN_WIDTH) * 32768);
  localparam logic signed [TOTW-1:0] CENTRE_Y = TOTW'(longint'(SCREEN_HEIGHT) * 32768);
  localparam logic [QW-1:0] MAG_LIMIT = {1'b1, {(QW-1){1'b0}}};
  localparam logic signed [TOTW-1:0] SAT_MAX = $signed({{(TOTW-31){1'b0}}, {31{1'b1}}});
  localparam logic signed [TOTW-1:0] SAT_MIN = $signed({{(TOTW-31){1'b1}}, {31{1'b0}}});
  localparam logic signed [PRW:0] ROUND_HALF = $signed({{(PRW-27){1'b0}}, 1'b1, 27'b0});

  typedef struct packed {
    logic nx_neg;
    logic ny_neg;
    logic nx_zero;
    logic ny_zero;
    logic d_neg;
    logic d_zero;
    logic z_zero;
  } side_t;

  function automatic logic signed [CW-1:0] ext33(input logic signed [32:0] v);
    return $signed({{(CW-33){v[32]}}, v});
  endfunction

  function automatic logic signed [CW-1:0] rnd_sum(input logic signed [PRW-1:0] p,
                                                    input logic signed [PRW-1:0] q);
    logic signed [PRW:0] s;
    s = $signed({p[PRW-1], p}) + $signed({q[PRW-1], q}) + ROUND_HALF;
    s = s >>> 28;
    return s[CW-1:0];
  endfunction

  function automatic logic [PRW+QW-1:0] div_step(input logic [PRW-1:0] rem,
                                                 input logic [QW-1:0] lo,
                                                 input logic [PRW-1:0] d);
    logic [PRW:0] t, r;
    logic ge;
    t = {rem, lo[QW-1]};
    ge = (t >= {1'b0, d});
    r = ge ? t - {1'b0, d} : t;
    return {r[PRW-1:0], lo[QW-2:0], ge};
  endfunction

  function automatic logic [32:0] finish(input logic [QW-1:0] q, input logic sat,
                                         input logic dz, input logic nzero,
                                         input logic nneg, input logic dneg,
                                         input logic signed [TOTW-1:0] centre);
    logic [QW-1:0] mag;
    logic neg, flag;
    logic signed [TOTW-1:0] total;
    logic [31:0] val;
    if (dz) begin
      mag = nzero ? '0 : MAG_LIMIT;
      neg = nneg;
    end else if (sat) begin
      mag = MAG_LIMIT;
      neg = nneg ^ dneg;
    end else begin
      mag = (q > MAG_LIMIT) ? MAG_LIMIT : q;
      neg = nneg ^ dneg;
    end
    total = neg ? centre - $signed({2'b00, mag}) : centre + $signed({2'b00, mag});
    flag = 1'b0;
    val = total[31:0];
    if (total > SAT_MAX) begin
      val = 32'h7fffffff;
      flag = 1'b1;
    end else if (total < SAT_MIN) begin
      val = 32'h80000000;
      flag = 1'b1;
    end
    return {flag, val};
  endfunction

  logic signed [31:0] cam_x_r, cam_y_r, cam_z_r;
  logic signed [15:0] yaw_r, pitch_r, roll_r;
  logic [13:0] fov_r;
  cpp_trig_set_t trig;
  logic accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r <= '0;
      cam_y_r <= '0;
      cam_z_r <= '0;
      yaw_r <= '0;
      pitch_r <= '0;
      roll_r <= '0;
      fov_r <= 14'd5760;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CAMERA_X:      cam_x_r <= cfg_data;
        CFG_CAMERA_Y:      cam_y_r <= cfg_data;
        CFG_CAMERA_Z:      cam_z_r <= cfg_data;
        CFG_CAMERA_YAW:    yaw_r <= cfg_data[15:0];
        CFG_CAMERA_PITCH:  pitch_r <= cfg_data[15:0];
        CFG_CAMERA_ROLL:   roll_r <= cfg_data[15:0];
        CFG_FIELD_OF_VIEW: fov_r <= cfg_data[13:0];
        default: begin
        end
      endcase
    end
  end

  cpp_trig u_trig (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (cfg_we),
    .yaw     (yaw_r),
    .pitch   (pitch_r),
    .roll    (roll_r),
    .fov     (fov_r),
    .busy    (busy),
    .trig    (trig)
  );

  assign accept = start && !busy;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r;
  logic signed [32:0] x1_r, y1_r, z1_r;
  logic signed [PRW-1:0] p2_ac_r, p2_bs_r, p2_bc_r, p2_as_r;
  logic signed [CW-1:0] y2_r, x3_r, y3_r, z3_r;
  logic signed [PRW-1:0] p4_ac_r, p4_bs_r, p4_bc_r, p4_as_r;
  logic signed [CW-1:0] x4_r, x5_r, y5_r, z5_r;
  logic signed [PRW-1:0] p6_ac_r, p6_bs_r, p6_bc_r, p6_as_r;
  logic signed [CW-1:0] z6_r, x7_r, y7_r, z7_r;
  logic signed [PRW-1:0] nx8_r, ny8_r, d8_r;
  logic zz8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    x1_r <= $signed({in_point_x[31], in_point_x}) - $signed({cam_x_r[31], cam_x_r});
    y1_r <= $signed({in_point_y[31], in_point_y}) - $signed({cam_y_r[31], cam_y_r});
    z1_r <= $signed({in_point_z[31], in_point_z}) - $signed({cam_z_r[31], cam_z_r});

    p2_ac_r <= ext33(x1_r) * trig.yaw_cos;
    p2_bs_r <= ext33(z1_r) * trig.yaw_sin;
    p2_bc_r <= ext33(z1_r) * trig.yaw_cos;
    p2_as_r <= ext33(x1_r) * trig.yaw_sin;
    y2_r <= ext33(y1_r);

    x3_r <= rnd_sum(p2_ac_r, p2_bs_r);
    z3_r <= rnd_sum(p2_bc_r, -p2_as_r);
    y3_r <= y2_r;

    p4_ac_r <= z3_r * trig.pitch_cos;
    p4_bs_r <= y3_r * trig.pitch_sin;
    p4_bc_r <= y3_r * trig.pitch_cos;
    p4_as_r <= z3_r * trig.pitch_sin;
    x4_r <= x3_r;

    z5_r <= rnd_sum(p4_ac_r, p4_bs_r);
    y5_r <= rnd_sum(p4_bc_r, -p4_as_r);
    x5_r <= x4_r;

    p6_ac_r <= x5_r * trig.roll_cos;
    p6_bs_r <= y5_r * trig.roll_sin;
    p6_bc_r <= y5_r * trig.roll_cos;
    p6_as_r <= x5_r * trig.roll_sin;
    z6_r <= z5_r;

    x7_r <= rnd_sum(p6_ac_r, p6_bs_r);
    y7_r <= rnd_sum(p6_bc_r, -p6_as_r);
    z7_r <= z6_r;

    nx8_r <= x7_r * trig.fov_cos;
    ny8_r <= y7_r * trig.fov_cos;
    d8_r <= z7_r * trig.fov_sin;
    zz8_r <= (z7_r == '0);
  end

  logic dv_r [QW+1];
  logic [PRW-1:0] rx_r [QW+1];
  logic [PRW-1:0] ry_r [QW+1];
  logic [QW-1:0] lx_r [QW+1];
  logic [QW-1:0] ly_r [QW+1];
  logic [PRW-1:0] d_r [QW+1];
  side_t sd_r [QW+1];
  logic satx_r [1:QW];
  logic saty_r [1:QW];

  logic [PRW-1:0] ux9, uy9, ud9;
  logic [PW-1:0] px9, py9;
  side_t side9;

  always_comb begin
    ux9 = nx8_r[PRW-1] ? $unsigned(-nx8_r) : $unsigned(nx8_r);
    uy9 = ny8_r[PRW-1] ? $unsigned(-ny8_r) : $unsigned(ny8_r);
    ud9 = d8_r[PRW-1] ? $unsigned(-d8_r) : $unsigned(d8_r);
    px9 = PW'(ux9) * PW'(SCALE);
    py9 = PW'(uy9) * PW'(SCALE);
    side9.nx_neg = nx8_r[PRW-1];
    side9.ny_neg = !ny8_r[PRW-1] && (ny8_r != '0);
    side9.nx_zero = (nx8_r == '0);
    side9.ny_zero = (ny8_r == '0);
    side9.d_neg = d8_r[PRW-1];
    side9.d_zero = (d8_r == '0);
    side9.z_zero = zz8_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else begin
      dv_r[0] <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    rx_r[0] <= PRW'(px9[PW-1:QW]);
    ry_r[0] <= PRW'(py9[PW-1:QW]);
    lx_r[0] <= px9[QW-1:0];
    ly_r[0] <= py9[QW-1:0];
    d_r[0] <= ud9;
    sd_r[0] <= side9;
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [PRW+QW-1:0] sx, sy;
    logic satx_in, saty_in;

    assign sx = div_step(rx_r[k], lx_r[k], d_r[k]);
    assign sy = div_step(ry_r[k], ly_r[k], d_r[k]);

    if (k == 0) begin : g_chk
      assign satx_in = (rx_r[0] >= d_r[0]);
      assign saty_in = (ry_r[0] >= d_r[0]);
    end else begin : g_pass
      assign satx_in = satx_r[k];
      assign saty_in = saty_r[k];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else begin
        dv_r[k+1] <= dv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      rx_r[k+1] <= sx[PRW+QW-1:QW];
      lx_r[k+1] <= sx[QW-1:0];
      ry_r[k+1] <= sy[PRW+QW-1:QW];
      ly_r[k+1] <= sy[QW-1:0];
      d_r[k+1] <= d_r[k];
      sd_r[k+1] <= sd_r[k];
      satx_r[k+1] <= satx_in;
      saty_r[k+1] <= saty_in;
    end
  end

  logic [32:0] fin_x, fin_y;
  logic out_valid_r, out_oor_r;
  logic signed [31:0] out_screen_x_r, out_screen_y_r;

  assign fin_x = finish(lx_r[QW], satx_r[QW], sd_r[QW].d_zero, sd_r[QW].nx_zero,
                        sd_r[QW].nx_neg, sd_r[QW].d_neg, CENTRE_X);
  assign fin_y = finish(ly_r[QW], saty_r[QW], sd_r[QW].d_zero, sd_r[QW].ny_zero,
                        sd_r[QW].ny_neg, sd_r[QW].d_neg, CENTRE_Y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    out_screen_x_r <= fin_x[31:0];
    out_screen_y_r <= fin_y[31:0];
    out_oor_r <= fin_x[32] | fin_y[32] | sd_r[QW].d_zero | sd_r[QW].z_zero;
  end

  assign out_valid = out_valid_r;
  assign out_screen_x = out_screen_x_r;
  assign out_screen_y = out_screen_y_r;
  assign out_out_of_range = out_oor_r;

  a_cfg_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> busy)
    else $error("trig table not rebuilt after register write");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_r[QW] && !satx_r[QW] && !sd_r[QW].d_zero) |-> (rx_r[QW] < d_r[QW]))
    else $error("divider remainder out of bound");

  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_r[QW] && sd_r[QW].d_zero) |=> (out_valid && out_out_of_range))
    else $error("zero denominator not flagged");

endmodule
